/* hdl/tlcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcc_pkg: shared types and constants for the touch lamp color controller
// Item and result payload structs, touch machine codes, register map and
// the sizing of the result queue.
// ----------------------------------------------------------------------------
package tlcc_pkg;

	// default color table depth
	localparam int TABLE_DEPTH_DEFAULT = 16;

	// item kinds
	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// register map, word index into the APB space
	localparam int          ADDR_W        = 5;
	localparam logic [2:0] REG_FADE_STEP = 3'd0;
	localparam logic [2:0] REG_POLL      = 3'd1;
	localparam logic [2:0] REG_IGNORE    = 3'd2;
	localparam logic [2:0] REG_HOLD      = 3'd3;
	localparam logic [2:0] REG_SHUTDOWN  = 3'd4;
	localparam logic [2:0] REG_COUNT     = 3'd5;

	// register reset values
	localparam logic [15:0] FADE_STEP_RST = 16'd10;
	localparam logic [15:0] POLL_RST      = 16'd50;
	localparam logic [15:0] IGNORE_RST    = 16'd1000;
	localparam logic [15:0] HOLD_RST      = 16'd200;
	localparam logic [31:0] SHUTDOWN_RST  = 32'd0;
	localparam logic [4:0]  COUNT_RST     = 5'd16;

	// uv stepping
	localparam logic [7:0]  UV_STEP  = 8'h0F;
	localparam logic [7:0]  UV_TOP   = 8'hF0;
	localparam logic [7:0]  UV_FLOOR = 8'h0F;
	localparam logic [31:0] UV_START = 32'h0000_000F;

	// result queue
	localparam int OQ_DEPTH = 3;
	localparam int OQ_PW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// touch machine states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UP   = 5'b00010,
		ST_DOWN = 5'b00100,
		ST_UV   = 5'b01000,
		ST_BOTH = 5'b10000
	} touch_state_t;

	typedef struct packed {
		logic        req_type;
		logic        touch_up;
		logic        touch_down;
		logic        touch_uv;
		logic [3:0]  entry_index;
		logic [23:0] entry_rgb;
	} item_t;

	typedef struct packed {
		logic [7:0] red_level;
		logic [7:0] green_level;
		logic [7:0] blue_level;
		logic [7:0] uv_level;
	} result_t;

endpackage

/* hdl/tlcc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tlcc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/tlcc_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcc_out_fifo: small result queue
// Absorbs results while the consumer stalls; occupancy feeds the input credit.
// ----------------------------------------------------------------------------
module tlcc_out_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  tlcc_pkg::result_t          push_data,
	output logic                       valid,
	input  logic                       stall,
	output tlcc_pkg::result_t          data,
	output logic [tlcc_pkg::OQ_CW-1:0] count
);

	localparam logic [tlcc_pkg::OQ_PW-1:0] LAST_PTR = tlcc_pkg::OQ_PW'(tlcc_pkg::OQ_DEPTH - 1);
	localparam logic [tlcc_pkg::OQ_CW-1:0] FULL_CNT = tlcc_pkg::OQ_CW'(tlcc_pkg::OQ_DEPTH);

	tlcc_pkg::result_t             entry_q [tlcc_pkg::OQ_DEPTH];
	logic [tlcc_pkg::OQ_PW-1:0]    wr_ptr_q;
	logic [tlcc_pkg::OQ_PW-1:0]    rd_ptr_q;
	logic [tlcc_pkg::OQ_CW-1:0]    count_q;
	logic                          pop;

	assign valid = (count_q != '0);
	assign pop   = valid && !stall;
	assign data  = entry_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == FULL_CNT) |-> (!push || pop))
		else $error("result queue overflow");

endmodule

/* hdl/touch_lamp_color_controller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_lamp_color_controller_unit: touch lamp color controller
// Polls a five-state touch machine, steps through a color table in RAM or
// steps UV brightness, and fades four channels toward their target.
// ----------------------------------------------------------------------------
//
// Channel   Ports                               Transfer when
// --------  ----------------------------------  ------------------------------
// item      item_valid, item_stall, item        item_valid && !item_stall
// result    result_valid, result_stall, result  result_valid && !result_stall
// config    psel penable pwrite paddr pwdata    psel && penable && pwrite
//           prdata pready (always high)
//
// Cycles: one item per cycle sustained while item_stall stays low. Stage 1
// works in the cycle the item transfers (counters, touch machine, table RAM
// read at the transfer edge); stage 2 takes the next cycle (target select
// from RAM data, fade) and pushes the result into the queue at the end of
// that cycle, so the result is registered in the queue before it transfers.
// Reset: arst_n clears all control state; the color table holds no valid
// bits and needs no clearing pass, so items are taken right after reset.
// Stalls: the three-entry result queue absorbs results; item_stall rises
// when queued plus in-flight results reach the queue depth.
// ----------------------------------------------------------------------------
module touch_lamp_color_controller_unit #(
	parameter int TABLE_DEPTH = tlcc_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          item_valid,
	output logic                          item_stall,
	input  tlcc_pkg::item_t               item,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output tlcc_pkg::result_t             result,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tlcc_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int           AW      = $clog2(TABLE_DEPTH);
	localparam logic [AW-1:0] POS_TOP = AW'(TABLE_DEPTH - 1);

	// saturating tick counter
	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// move each byte lane one step toward its target
	function automatic logic [31:0] fade_step(input logic [31:0] cur, input logic [31:0] tgt);
		logic [31:0] res;
		logic [7:0]  c;
		logic [7:0]  t;
		res = '0;
		for (int i = 0; i < 4; i++) begin
			c = cur[8*i +: 8];
			t = tgt[8*i +: 8];
			if (t < c) begin
				c = c - 8'd1;
			end else if (t > c) begin
				c = c + 8'd1;
			end
			res[8*i +: 8] = c;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [15:0] fade_period_q;
	logic [15:0] poll_period_q;
	logic [15:0] ignore_period_q;
	logic [15:0] hold_period_q;
	logic [31:0] shutdown_color_q;
	logic [4:0]  color_count_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_period_q    <= tlcc_pkg::FADE_STEP_RST;
			poll_period_q    <= tlcc_pkg::POLL_RST;
			ignore_period_q  <= tlcc_pkg::IGNORE_RST;
			hold_period_q    <= tlcc_pkg::HOLD_RST;
			shutdown_color_q <= tlcc_pkg::SHUTDOWN_RST;
			color_count_q    <= tlcc_pkg::COUNT_RST;
		end else if (cfg_we) begin
			case (paddr[4:2])
				tlcc_pkg::REG_FADE_STEP: fade_period_q    <= pwdata[15:0];
				tlcc_pkg::REG_POLL:      poll_period_q    <= pwdata[15:0];
				tlcc_pkg::REG_IGNORE:    ignore_period_q  <= pwdata[15:0];
				tlcc_pkg::REG_HOLD:      hold_period_q    <= pwdata[15:0];
				tlcc_pkg::REG_SHUTDOWN:  shutdown_color_q <= pwdata;
				tlcc_pkg::REG_COUNT:     color_count_q    <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			tlcc_pkg::REG_FADE_STEP: prdata = {16'd0, fade_period_q};
			tlcc_pkg::REG_POLL:      prdata = {16'd0, poll_period_q};
			tlcc_pkg::REG_IGNORE:    prdata = {16'd0, ignore_period_q};
			tlcc_pkg::REG_HOLD:      prdata = {16'd0, hold_period_q};
			tlcc_pkg::REG_SHUTDOWN:  prdata = shutdown_color_q;
			tlcc_pkg::REG_COUNT:     prdata = {27'd0, color_count_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// state registers (stage 1 owns these)
	// ------------------------------------------------------------------
	tlcc_pkg::touch_state_t state_q;
	logic [15:0]            poll_q;
	logic [15:0]            hold_q;
	logic [15:0]            fade_q;
	logic                   long_q;
	logic [AW-1:0]          pos_q;
	logic                   uv_q;
	logic                   shut_q;
	logic [31:0]            saved_q;
	logic [31:0]            pre_q;
	// stage 2 owns these
	logic [31:0]            target_q;
	logic [31:0]            shown_q;

	// stage 1 -> stage 2
	logic                   v_s1;
	logic [31:0]            tgt_s1;
	logic                   load_s1;
	logic                   fade_s1;

	// table RAM
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic                   ram_re;
	logic [23:0]            ram_rdata;

	// result queue
	logic [tlcc_pkg::OQ_CW-1:0] oq_count;
	tlcc_pkg::result_t          push_data;

	logic                   acc;
	logic                   tick;
	logic [31:0]            tgt_fin;
	logic [31:0]            target_cur;
	logic [31:0]            shown_nxt;
	logic [AW-1:0]          pos_max;

	// next-state of stage 1
	tlcc_pkg::touch_state_t n_state;
	logic [15:0]            n_poll;
	logic [15:0]            n_hold;
	logic [15:0]            n_fade;
	logic                   n_long;
	logic [AW-1:0]          n_pos;
	logic                   n_uv;
	logic                   n_shut;
	logic [31:0]            n_saved;
	logic [31:0]            n_pre;
	logic [31:0]            n_tgt;
	logic                   n_load;
	logic                   n_fade_go;
	logic                   ev_up;
	logic                   ev_down;
	logic                   ev_uv;
	logic                   ev_both;
	logic                   hold_hit;
	logic [15:0]            period;

	// hold input while the queue, counting the result in flight, is full
	assign item_stall = ({1'b0, oq_count} + {{tlcc_pkg::OQ_CW{1'b0}}, v_s1})
		>= (tlcc_pkg::OQ_CW + 1)'(tlcc_pkg::OQ_DEPTH);
	assign acc  = item_valid && !item_stall;
	assign tick = acc && (item.req_type == tlcc_pkg::REQ_TICK);

	// stage 2 target: freshly read table color replaces the stage 1 value
	assign tgt_fin    = load_s1 ? {ram_rdata, 8'h00} : tgt_s1;
	// forward the in-flight target to the item now in stage 1
	assign target_cur = v_s1 ? tgt_fin : target_q;
	assign shown_nxt  = fade_s1 ? fade_step(shown_q, tgt_fin) : shown_q;

	// highest table position that up may reach
	always_comb begin
		if (color_count_q == 5'd0) begin
			pos_max = '0;
		end else if ({27'd0, color_count_q} > 32'(TABLE_DEPTH)) begin
			pos_max = POS_TOP;
		end else begin
			pos_max = AW'(color_count_q - 5'd1);
		end
	end

	// ------------------------------------------------------------------
	// stage 1: counters, touch machine, events
	// ------------------------------------------------------------------
	always_comb begin
		n_state   = state_q;
		n_poll    = poll_q;
		n_hold    = hold_q;
		n_fade    = fade_q;
		n_long    = long_q;
		n_pos     = pos_q;
		n_uv      = uv_q;
		n_shut    = shut_q;
		n_saved   = saved_q;
		n_pre     = pre_q;
		n_tgt     = target_cur;
		n_load    = 1'b0;
		n_fade_go = 1'b0;
		ev_up     = 1'b0;
		ev_down   = 1'b0;
		ev_uv     = 1'b0;
		ev_both   = 1'b0;
		period    = long_q ? ignore_period_q : poll_period_q;
		hold_hit  = 1'b0;

		if (tick) begin
			n_poll   = sat_inc(poll_q);
			n_hold   = sat_inc(hold_q);
			n_fade   = sat_inc(fade_q);
			hold_hit = (n_hold >= hold_period_q);

			if (n_poll >= period) begin
				n_poll = '0;
				n_long = 1'b0;
				case (state_q)
					tlcc_pkg::ST_UP: begin
						if (item.touch_down) begin
							n_state = tlcc_pkg::ST_BOTH;
						end
						if (!item.touch_up) begin
							n_state = tlcc_pkg::ST_IDLE;
						end
						if (hold_hit) begin
							n_hold = '0;
							ev_up  = 1'b1;
						end
					end
					tlcc_pkg::ST_DOWN: begin
						if (item.touch_up) begin
							n_state = tlcc_pkg::ST_BOTH;
						end
						if (!item.touch_down) begin
							n_state = tlcc_pkg::ST_IDLE;
						end
						if (hold_hit) begin
							n_hold  = '0;
							ev_down = 1'b1;
						end
					end
					tlcc_pkg::ST_UV: begin
						if (!item.touch_uv) begin
							n_state = tlcc_pkg::ST_IDLE;
						end
						if (hold_hit) begin
							n_hold = '0;
							ev_uv  = 1'b1;
						end
					end
					tlcc_pkg::ST_BOTH: begin
						if (!item.touch_up || !item.touch_down) begin
							n_state = tlcc_pkg::ST_IDLE;
						end else begin
							ev_both = 1'b1;
						end
					end
					default: begin
						// idle: last matching pad wins
						n_state = tlcc_pkg::ST_IDLE;
						if (item.touch_up) begin
							n_state = tlcc_pkg::ST_UP;
						end
						if (item.touch_down) begin
							n_state = tlcc_pkg::ST_DOWN;
						end
						if (item.touch_uv) begin
							n_state = tlcc_pkg::ST_UV;
						end
						if (n_state != tlcc_pkg::ST_IDLE) begin
							n_hold = '0;
						end
					end
				endcase
			end

			if (n_fade >= fade_period_q) begin
				n_fade    = '0;
				n_fade_go = 1'b1;
			end
		end

		// any single-pad hold event in shutdown just restores the old color
		if ((ev_up || ev_down || ev_uv) && shut_q) begin
			n_tgt  = pre_q;
			n_shut = 1'b0;
		end else if (ev_up) begin
			if (uv_q) begin
				if (target_cur[7:0] < tlcc_pkg::UV_TOP) begin
					n_tgt[7:0] = target_cur[7:0] + tlcc_pkg::UV_STEP;
				end
			end else if (pos_q < pos_max) begin
				n_pos  = pos_q + 1'b1;
				n_load = 1'b1;
			end
		end else if (ev_down) begin
			if (uv_q) begin
				if (target_cur[7:0] > tlcc_pkg::UV_FLOOR) begin
					n_tgt[7:0] = target_cur[7:0] - tlcc_pkg::UV_STEP;
				end
			end else if (pos_q != '0) begin
				n_pos  = pos_q - 1'b1;
				n_load = 1'b1;
			end
		end else if (ev_uv) begin
			if (!uv_q) begin
				n_uv    = 1'b1;
				n_saved = target_cur;
				n_tgt   = tlcc_pkg::UV_START;
			end else begin
				n_uv  = 1'b0;
				n_tgt = saved_q;
			end
		end else if (ev_both) begin
			if (!shut_q) begin
				n_pre = target_cur;
			end
			n_tgt  = shutdown_color_q;
			n_shut = 1'b1;
			n_long = 1'b1;
		end
	end

	// table access: write on table-write items, read the new position on a step
	assign ram_we    = acc && (item.req_type == tlcc_pkg::REQ_WRITE)
		&& ({28'd0, item.entry_index} < 32'(TABLE_DEPTH));
	assign ram_waddr = AW'(item.entry_index);
	assign ram_re    = n_load;

	tlcc_ram #(
		.WIDTH(24),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(item.entry_rgb),
		.re   (ram_re),
		.raddr(n_pos),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlcc_pkg::ST_IDLE;
			poll_q  <= '0;
			hold_q  <= '0;
			fade_q  <= '0;
			long_q  <= 1'b0;
			pos_q   <= '0;
			uv_q    <= 1'b0;
			shut_q  <= 1'b0;
			saved_q <= '0;
			pre_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= acc;
			if (tick) begin
				state_q <= n_state;
				poll_q  <= n_poll;
				hold_q  <= n_hold;
				fade_q  <= n_fade;
				long_q  <= n_long;
				pos_q   <= n_pos;
				uv_q    <= n_uv;
				shut_q  <= n_shut;
				saved_q <= n_saved;
				pre_q   <= n_pre;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tgt_s1  <= n_tgt;
			load_s1 <= n_load;
			fade_s1 <= n_fade_go;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: commit target, fade, queue the result
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			shown_q  <= '0;
		end else if (v_s1) begin
			target_q <= tgt_fin;
			shown_q  <= shown_nxt;
		end
	end

	assign push_data.red_level   = shown_nxt[31:24];
	assign push_data.green_level = shown_nxt[23:16];
	assign push_data.blue_level  = shown_nxt[15:8];
	assign push_data.uv_level    = shown_nxt[7:0];

	tlcc_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (v_s1),
		.push_data(push_data),
		.valid    (result_valid),
		.stall    (result_stall),
		.data     (result),
		.count    (oq_count)
	);

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (oq_count < tlcc_pkg::OQ_CW'(tlcc_pkg::OQ_DEPTH)))
		else $error("result in flight without queue room");

	a_shutdown_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(shut_q) |-> $past(state_q == tlcc_pkg::ST_BOTH))
		else $error("shutdown entered outside the both-pads state");

	a_uv_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(uv_q != $past(uv_q)) |-> $past(state_q == tlcc_pkg::ST_UV))
		else $error("uv mode toggled outside the uv state");

	a_pos_read: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != $past(pos_q)) |-> ($past(ram_re) && load_s1))
		else $error("table position moved without a table read");

endmodule
